// ===== sv/kfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_pkg: shared types and constants for the keyed FNV seed unit
// FNV-1a 64 and SplitMix64 constants, queue item type, multiplier bundles.
// ----------------------------------------------------------------------------
package kfs_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] GOLDEN     = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_A      = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_B      = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned KEY_LEN_W          = 16;
    localparam int unsigned KFS_MAX_KEY_BYTES  = 65535;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       byte_present;
        logic       last_byte;
    } kfs_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MIX_A,
        BK_MIX_B,
        BK_OUT
    } bk_state_t;

    // One FNV-1a step: xor the byte in, multiply by 2^40 + 0x1b3 (low 64 bits).
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage
`default_nettype wire

// ===== sv/keyed_fnv_splitmix_seed_unit.sv =====
`default_nettype none
// Flow: an accepted key byte is registered in the queue, then absorbed into the
// registered hash in the engine; a last item then runs the SplitMix64 finalize.
// Throughput: one byte per cycle inside a key; a last item holds the engine
// for two 64-bit multiplies on the 32x32 unit.
// Reset and every ride_seed write start a seeded basis precompute over the eight
// seed bytes; a new key waits for it. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// keyed_fnv_splitmix_seed_unit: keyed FNV-1a 64 element seed generator
// Hashes ride seed and key bytes, finalizes with SplitMix64, emits one seed.
// ----------------------------------------------------------------------------
module keyed_fnv_splitmix_seed_unit
    import kfs_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = KFS_MAX_KEY_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,    // ride_seed
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] key_byte
    input  wire logic [0:0]  s_tuser,      // [0] byte_present
    input  wire logic        s_tlast,      // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata       // [63:0] element_seed
);

    logic      item_valid;
    kfs_item_t item;
    logic      item_pop;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;

    kfs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    kfs_back #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    kfs_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

endmodule
`default_nettype wire

// ===== sv/kfs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_front: input acceptance and item queue
// Drops items that carry neither a byte nor an end mark, queues the rest.
// ----------------------------------------------------------------------------
module kfs_front
    import kfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] key_byte
    input  wire logic [0:0] s_tuser,    // [0] byte_present
    input  wire logic       s_tlast,
    output logic            item_valid,
    output kfs_item_t       item,
    input  wire logic       item_pop
);

    localparam int unsigned DEPTH = 2;

    kfs_item_t  mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign s_tready   = (count_reg != 2'(DEPTH));
    assign push       = s_tvalid && s_tready && (s_tuser[0] || s_tlast);
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{key_byte: s_tdata, byte_present: s_tuser[0],
                                     last_byte: s_tlast};
        end
    end

endmodule
`default_nettype wire

// ===== sv/kfs_mul64.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_mul64: 64 x 64 multiplier, low 64 bits of the product
// Three 32 x 32 partial products, one per cycle; done pulses when p is final.
// ----------------------------------------------------------------------------
module kfs_mul64
    import kfs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam logic [1:0] LAST_STEP = 2'd2;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb begin
        case (step_reg)
            2'd0: begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1: begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default: begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
        prod = {32'd0, op_x} * {32'd0, op_y};
        // cross terms only reach the upper half
        if (step_reg == 2'd0) begin
            acc_next = prod;
        end else begin
            acc_next = acc_reg + {prod[31:0], 32'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule
`default_nettype wire

// ===== sv/kfs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfs_back: hash engine
// Seeded basis precompute, FNV-1a absorb, SplitMix64 finalize, output register.
// ----------------------------------------------------------------------------
module kfs_back
    import kfs_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = KFS_MAX_KEY_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        item_valid,
    input  wire kfs_item_t   item,
    output logic             item_pop,
    output mul_req_t         mul_req,
    input  wire mul_rsp_t    mul_rsp,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata
);

    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    bk_state_t            state_reg, state_next;
    logic [63:0]          seed_reg;
    logic [63:0]          basis_reg;
    logic [2:0]           basis_cnt_reg;
    logic                 basis_busy_reg;
    logic [63:0]          hash_reg;
    logic [KEY_LEN_W-1:0] len_reg;
    logic                 in_key_reg;
    logic [63:0]          work_reg, work_next;
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic                 load_out;

    logic [63:0]          h_start, h_item;
    logic [KEY_LEN_W-1:0] len_start, len_item;
    logic [63:0]          z0;

    // a key starts from the precomputed seeded basis
    always_comb begin
        h_start   = in_key_reg ? hash_reg : basis_reg;
        len_start = in_key_reg ? len_reg : '0;
        if (item.byte_present) begin
            h_item   = fnv_absorb(h_start, item.key_byte);
            len_item = (len_start < MAX_LEN) ? len_start + 1'b1 : len_start;
        end else begin
            h_item   = h_start;
            len_item = len_start;
        end
        z0 = (work_reg ^ ({{(64-KEY_LEN_W){1'b0}}, len_reg} + GOLDEN)) + GOLDEN;
    end

    always_comb begin
        state_next = state_reg;
        item_pop   = 1'b0;
        mul_req    = '{start: 1'b0, a: work_reg, b: MIX_A};
        work_next  = work_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (item_valid && (in_key_reg || !basis_busy_reg)) begin
                    item_pop = 1'b1;
                    if (item.last_byte) begin
                        work_next  = h_item;
                        state_next = BK_PREP;
                    end
                end
            end
            BK_PREP: begin
                mul_req    = '{start: 1'b1, a: z0 ^ (z0 >> 30), b: MIX_A};
                state_next = BK_MIX_A;
            end
            BK_MIX_A: begin
                if (mul_rsp.done) begin
                    mul_req    = '{start: 1'b1, a: mul_rsp.p ^ (mul_rsp.p >> 27), b: MIX_B};
                    state_next = BK_MIX_B;
                end
            end
            BK_MIX_B: begin
                if (mul_rsp.done) begin
                    work_next  = mul_rsp.p;
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            seed_reg       <= 64'd0;
            basis_reg      <= FNV_BASIS;
            basis_cnt_reg  <= 3'd0;
            basis_busy_reg <= 1'b1;
            len_reg        <= '0;
            in_key_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (item_pop) begin
                len_reg    <= len_item;
                in_key_reg <= !item.last_byte;
            end
            // seed bytes are absorbed lowest first, one per cycle
            if (cfg_we) begin
                seed_reg       <= cfg_wdata;
                basis_reg      <= FNV_BASIS;
                basis_cnt_reg  <= 3'd0;
                basis_busy_reg <= 1'b1;
            end else if (basis_busy_reg) begin
                basis_reg     <= fnv_absorb(basis_reg, seed_reg[8*basis_cnt_reg +: 8]);
                basis_cnt_reg <= basis_cnt_reg + 3'd1;
                if (basis_cnt_reg == 3'd7) begin
                    basis_busy_reg <= 1'b0;
                end
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (item_pop) begin
            hash_reg <= h_item;
        end
        if (load_out) begin
            out_data_reg <= work_reg ^ (work_reg >> 31);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_start_after_basis: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_pop && !in_key_reg) |-> !basis_busy_reg)
        else $error("key started before seeded basis was ready");

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("key length exceeds bound");

    a_done_in_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == BK_MIX_A || state_reg == BK_MIX_B))
        else $error("multiplier result outside a finalize step");

    a_prep_to_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_PREP) |=> (state_reg == BK_MIX_A))
        else $error("finalize did not start the first multiply");
`endif

endmodule
`default_nettype wire
